// ===== design/qpot_pkg.sv =====
`timescale 1ns / 1ps
// Package for the quad paddle one-shot timer block: item structs, offsets,
// register indexes and shared constants. No dependencies.
package qpot_pkg;

    // Timer count, default and largest supported
    localparam int TIMERS_DEFAULT = 4;
    localparam int TIMERS_MAX     = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (paddr[2])
    localparam logic REG_THIRD_POS  = 1'b0;
    localparam logic REG_FOURTH_POS = 1'b1;

    localparam logic [7:0] POS_RESET = 8'd80;

    // Command codes
    typedef enum logic
    {
        CMD_TIME = 1'b0,
        CMD_BUS  = 1'b1
    } cmd_t;

    // Handled I/O offsets
    localparam logic [7:0] OFF_BUTTON0  = 8'h61;
    localparam logic [7:0] OFF_BUTTON1  = 8'h62;
    localparam logic [7:0] OFF_SLOT     = 8'h63;
    localparam logic [7:0] OFF_TIMER_LO = 8'h64;
    localparam logic [7:0] OFF_TIMER_HI = 8'h67;
    localparam logic [7:0] OFF_TRIGGER  = 8'h70;

    // Read values
    localparam logic [7:0] BUTTON_ON = 8'hA0;
    localparam logic [7:0] TIMER_ON  = 8'h80;

    // Input item
    typedef struct packed
    {
        cmd_t        cmd;
        logic [31:0] cycle_now;
        logic [7:0]  io_offset;
        logic        is_write;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic        button_a;
        logic        button_b;
        logic [7:0]  slot_number;
    } in_item_t;

    // Result item
    typedef struct packed
    {
        logic [7:0] read_data;
        logic       decoded;
    } out_item_t;

    // 11 * pos as shift-and-add: 8x + 2x + x
    function automatic logic [11:0] scale_pos(input logic [7:0] pos);
        return {1'b0, pos, 3'b000} + {3'b000, pos, 1'b0} + {4'b0000, pos};
    endfunction

endpackage

// ===== design/quad_paddle_one_shot_timer.sv =====
`timescale 1ns / 1ps
// Top level of the quad paddle one-shot timer block.
// Depends on qpot_pkg.

// Takes one item per clock unless out_ready stalls the output, and returns
// its result in the next cycle from a single output register; a new item is
// accepted whenever that register is empty or being drained in the same
// cycle. A time update stores the cycle count and idles every timer whose
// deadline it has passed; an access to 0x70 loads all timers with count +
// 11 * position in that same cycle. Paddle positions two and three come from
// the APB registers at 0x0 and 0x4 (reset 80).
module quad_paddle_one_shot_timer
    import qpot_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    // result output
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [31:0] deadline_reg [TIMERS];
    logic [31:0] cycle_reg;
    logic [7:0]  third_pos_reg;
    logic [7:0]  fourth_pos_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic        accept;
    logic        cfg_write;
    logic        is_time;
    logic        is_trigger;
    logic        timer_rd_on;
    out_item_t   result_next;

    // Position feeding timer i on a trigger
    function automatic logic [7:0] pos_of(input int i, input logic [7:0] sx,
        input logic [7:0] sy, input logic [7:0] p2, input logic [7:0] p3);
        case (i)
            0:       return sx;
            1:       return sy;
            2:       return p2;
            default: return p3;
        endcase
    endfunction

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign is_time    = (in_data.cmd == CMD_TIME);
    assign is_trigger = (in_data.cmd == CMD_BUS) && (in_data.io_offset == OFF_TRIGGER);

    // Running flag of the timer selected by a 0x64..0x67 read
    always_comb
    begin
        timer_rd_on = 1'b0;
        for (int i = 0; i < TIMERS; i++)
        begin
            if (in_data.io_offset[1:0] == 2'(i) && deadline_reg[i] != 32'd0)
            begin
                timer_rd_on = 1'b1;
            end
        end
    end

    // Result decode
    always_comb
    begin
        result_next.read_data = '0;
        result_next.decoded   = 1'b0;
        if (is_trigger)
        begin
            result_next.decoded = 1'b1;
        end
        else if (!is_time && !in_data.is_write)
        begin
            if (in_data.io_offset == OFF_BUTTON0)
            begin
                result_next.read_data = in_data.button_a ? BUTTON_ON : 8'h00;
                result_next.decoded   = 1'b1;
            end
            else if (in_data.io_offset == OFF_BUTTON1)
            begin
                result_next.read_data = in_data.button_b ? BUTTON_ON : 8'h00;
                result_next.decoded   = 1'b1;
            end
            else if (in_data.io_offset == OFF_SLOT)
            begin
                result_next.read_data = in_data.slot_number;
                result_next.decoded   = 1'b1;
            end
            else if (in_data.io_offset >= OFF_TIMER_LO && in_data.io_offset <= OFF_TIMER_HI)
            begin
                result_next.read_data = timer_rd_on ? TIMER_ON : 8'h00;
                result_next.decoded   = 1'b1;
            end
        end
    end

    // Cycle count and timer deadlines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg <= '0;
            for (int i = 0; i < TIMERS; i++)
            begin
                deadline_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (is_time)
            begin
                cycle_reg <= in_data.cycle_now;
                for (int i = 0; i < TIMERS; i++)
                begin
                    if (deadline_reg[i] != 32'd0 && in_data.cycle_now > deadline_reg[i])
                    begin
                        deadline_reg[i] <= '0;
                    end
                end
            end
            else if (is_trigger)
            begin
                for (int i = 0; i < TIMERS; i++)
                begin
                    deadline_reg[i] <= cycle_reg + {20'd0, scale_pos(pos_of(i,
                        in_data.stick_x, in_data.stick_y, third_pos_reg, fourth_pos_reg))};
                end
            end
        end
    end

    // Output register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            third_pos_reg  <= POS_RESET;
            fourth_pos_reg <= POS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_THIRD_POS)
            begin
                third_pos_reg <= pwdata[7:0];
            end
            else
            begin
                fourth_pos_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FOURTH_POS) ? {24'd0, fourth_pos_reg}
                                                 : {24'd0, third_pos_reg};

    // Checks
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted item produced no result");

    a_time_undecoded: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_time |=> !out_data.decoded && out_data.read_data == 8'h00)
        else $error("time update produced a decoded result");

    a_time_stored: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_time |=> cycle_reg == $past(in_data.cycle_now))
        else $error("cycle count not stored on time update");

    a_undecoded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.decoded |-> out_data.read_data == 8'h00)
        else $error("undecoded result carries data");

endmodule

// ===== bench/qpot_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the quad paddle one-shot timer: watches the item, result and
// configuration transfers, predicts each result and compares it.
// Depends on qpot_pkg.
module qpot_checker
    import qpot_pkg::*;
#(
    parameter int TIMERS = TIMERS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam logic [31:0] PADDLE_SCALE = 32'd11;

    // Shadow of the block state
    logic [31:0] deadline [TIMERS_MAX];
    logic [31:0] now_count;
    logic [7:0]  third_pos;
    logic [7:0]  fourth_pos;

    // Results still owed by the block, oldest first
    out_item_t   owed_results [$];

    // Applies one item to the shadow state and returns its result
    function automatic out_item_t paddle_port_result(input in_item_t item);
        out_item_t   res;
        logic [7:0]  pos [TIMERS_MAX];
        int          k;
        res = '0;
        if (item.cmd == CMD_TIME)
        begin
            now_count = item.cycle_now;
            // strictly past the deadline before a timer drops out
            for (k = 0; k < TIMERS_MAX; k++)
                if (deadline[k] != 32'd0 && now_count > deadline[k])
                    deadline[k] = 32'd0;
        end
        else if (item.io_offset == OFF_TRIGGER)
        begin
            // read or write both fire every timer
            pos[0] = item.stick_x;
            pos[1] = item.stick_y;
            pos[2] = third_pos;
            pos[3] = fourth_pos;
            for (k = 0; k < TIMERS_MAX; k++)
                if (k < TIMERS)
                    deadline[k] = now_count + 32'(pos[k]) * PADDLE_SCALE;
            res.decoded = 1'b1;
        end
        else if (!item.is_write)
        begin
            if (item.io_offset == OFF_BUTTON0)
            begin
                res.read_data = item.button_a ? BUTTON_ON : 8'h00;
                res.decoded   = 1'b1;
            end
            else if (item.io_offset == OFF_BUTTON1)
            begin
                res.read_data = item.button_b ? BUTTON_ON : 8'h00;
                res.decoded   = 1'b1;
            end
            else if (item.io_offset == OFF_SLOT)
            begin
                res.read_data = item.slot_number;
                res.decoded   = 1'b1;
            end
            else if (item.io_offset >= OFF_TIMER_LO && item.io_offset <= OFF_TIMER_HI)
            begin
                // a zero deadline means idle, also after a wrap to zero
                k = int'(item.io_offset - OFF_TIMER_LO);
                if (k < TIMERS && deadline[k] != 32'd0)
                    res.read_data = TIMER_ON;
                res.decoded = 1'b1;
            end
        end
        return res;
    endfunction

    // Track transfers at each edge: results first, then register writes, then new items
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < TIMERS_MAX; k++)
                deadline[k] = 32'd0;
            now_count  = 32'd0;
            third_pos  = POS_RESET;
            fourth_pos = POS_RESET;
            owed_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %02h/%0b",
                             $time, out_data.read_data, out_data.decoded);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (out_data.read_data !== want.read_data)
                    begin
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $time, want.read_data, out_data.read_data);
                        mismatches++;
                    end
                    if (out_data.decoded !== want.decoded)
                    begin
                        $display("%0t: decoded mismatch, expected %0b, actual %0b",
                                 $time, want.decoded, out_data.decoded);
                        mismatches++;
                    end
                end
            end

            // register write lands at the access phase
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_THIRD_POS)
                    third_pos = pwdata[7:0];
                else
                    fourth_pos = pwdata[7:0];
            end

            if (in_valid && in_ready)
                owed_results.push_back(paddle_port_result(in_data));
        end
        outstanding = owed_results.size();
    end

endmodule

// ===== bench/tb_quad_paddle_one_shot_timer.sv =====
`timescale 1ns / 1ps
// Testbench top for the quad paddle one-shot timer: clock, reset, stimulus,
// register setup and verdict. Depends on qpot_pkg, qpot_checker and the block.
module tb_quad_paddle_one_shot_timer;
    import qpot_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 420;
    localparam int HOLD_START   = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FIRST   = 1000;
    localparam int CALM_LAST    = 1400;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          mismatches;
    int          outstanding;
    int          items_sent;
    int          cycles;
    logic [31:0] clock_now;
    logic        hold_done;
    logic        calm;

    quad_paddle_one_shot_timer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    qpot_checker scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // no idling on either side in this stretch
    assign calm = items_sent >= CALM_FIRST && items_sent < CALM_LAST;

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls plus one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_START)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // Item with every field random
    function automatic in_item_t random_fields();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(input in_item_t item);
        while (!calm && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (item.cmd == CMD_TIME)
            clock_now = item.cycle_now;
    endtask

    task automatic send_time(input logic [31:0] count);
        in_item_t item;
        item = random_fields();
        item.cmd       = CMD_TIME;
        item.cycle_now = count;
        send_item(item);
    endtask

    task automatic send_bus(input logic [7:0] offset, input logic wr,
                            input logic [7:0] sx, input logic [7:0] sy);
        in_item_t item;
        item = random_fields();
        item.cmd       = CMD_BUS;
        item.io_offset = offset;
        item.is_write  = wr;
        item.stick_x   = sx;
        item.stick_y   = sy;
        send_item(item);
    endtask

    // Mostly plausible traffic: advancing time, triggers, port reads
    task automatic send_random();
        in_item_t item;
        int       pick;
        item = random_fields();
        pick = $urandom_range(99);
        if (pick < 33)
        begin
            item.cmd       = CMD_TIME;
            item.cycle_now = clock_now + 32'($urandom_range(3000));
        end
        else if (pick < 38)
        begin
            // small steps reach the deadline-equal case
            item.cmd       = CMD_TIME;
            item.cycle_now = clock_now + 32'($urandom_range(2));
        end
        else if (pick < 42)
            item.cmd = CMD_TIME;
        else if (pick < 52)
        begin
            item.cmd       = CMD_BUS;
            item.io_offset = OFF_TRIGGER;
        end
        else if (pick < 90)
        begin
            item.cmd       = CMD_BUS;
            item.io_offset = OFF_BUTTON0 + 8'($urandom_range(6));
            item.is_write  = ($urandom_range(9) == 0);
        end
        else
            item.cmd = CMD_BUS;
        send_item(item);
    endtask

    // Let every owed result come back before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] third, input logic [7:0] fourth);
        drain();
        write_reg(REG_THIRD_POS, third);
        write_reg(REG_FOURTH_POS, fourth);
        repeat (PHASE_ITEMS) send_random();
    endtask

    // Main sequence
    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cycles     = 0;
        items_sent = 0;
        clock_now  = 32'd0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all timers idle out of reset
        send_bus(OFF_TIMER_LO,         1'b0, 8'h00, 8'h00);
        send_bus(OFF_TIMER_LO + 8'd1,  1'b0, 8'h00, 8'h00);
        send_bus(OFF_TIMER_LO + 8'd2,  1'b0, 8'h00, 8'h00);
        send_bus(OFF_TIMER_HI,         1'b0, 8'h00, 8'h00);
        // trigger with stick extremes, then poll each timer
        send_time(32'd100);
        send_bus(OFF_TRIGGER,          1'b0, 8'h00, 8'hFF);
        send_bus(OFF_TIMER_LO,         1'b0, 8'h00, 8'h00);
        send_bus(OFF_TIMER_LO + 8'd1,  1'b0, 8'h00, 8'h00);
        send_bus(OFF_TIMER_LO + 8'd2,  1'b0, 8'h00, 8'h00);
        send_bus(OFF_TIMER_HI,         1'b0, 8'h00, 8'h00);
        // count equal to deadline keeps running, one past stops it
        send_time(32'd100);
        send_bus(OFF_TIMER_LO,         1'b0, 8'h00, 8'h00);
        send_time(32'd101);
        send_bus(OFF_TIMER_LO,         1'b0, 8'h00, 8'h00);
        // buttons and slot, then writes to slot and trigger and an unhandled read
        send_bus(OFF_BUTTON0,          1'b0, 8'h00, 8'h00);
        send_bus(OFF_BUTTON1,          1'b0, 8'h00, 8'h00);
        send_bus(OFF_SLOT,             1'b0, 8'h00, 8'h00);
        send_bus(OFF_SLOT,             1'b1, 8'h00, 8'h00);
        send_bus(OFF_TRIGGER,          1'b1, 8'hFF, 8'h00);
        send_bus(8'hFF,                1'b0, 8'h00, 8'h00);
        // deadline of paddle two wraps to exactly zero
        send_time(32'hFFFF_FC90);
        send_bus(OFF_TRIGGER,          1'b1, 8'h80, 8'h7F);
        send_bus(OFF_TIMER_LO + 8'd2,  1'b0, 8'h00, 8'h00);
        send_bus(OFF_TIMER_HI,         1'b0, 8'h00, 8'h00);
        send_time(32'hFFFF_FFFF);

        run_phase(8'h00, 8'hFF);
        run_phase(8'hFF, 8'h00);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)));
        run_phase(8'hFF, 8'hFF);
        run_phase(8'h00, 8'h00);

        drain();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
